[rtl/keystone_homography_warp_macros.svh]
// Assertion macros shared by the keystone warp RTL.
`ifndef KEYSTONE_HOMOGRAPHY_WARP_MACROS_SVH
`define KEYSTONE_HOMOGRAPHY_WARP_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset.
`define KHW_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define KHW_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/khw_pkg.sv]
// Types and constants of the keystone homography warp.
`timescale 1ns / 1ps

package khw_pkg;

    localparam int DIV_STEPS = 17;              // quotient bits of x/w and y/w
    localparam int NDIV      = DIV_STEPS + 2;   // prep, overflow check, steps
    localparam int NSTAGE    = NDIV + 3;        // products, sums, NDIV, output

    typedef logic signed [15:0] corner_t;
    typedef logic signed [31:0] coef_t;

    localparam corner_t CORNER_ONE = 16'sh4000;
    localparam coef_t   COEF_ONE   = 32'sh0100_0000;
    localparam coef_t   COEF_MIN   = 32'sh8000_0000;
    localparam coef_t   COEF_MAX   = 32'sh7fff_ffff;
    localparam logic signed [49:0] W_BIAS = 50'sh40_0000_0000;  // 1.0 in Q38

    localparam logic [5:0] SDIV_LAST = 6'd32;   // last serial quotient step
    localparam logic [5:0] SDIV_DONE = 6'd33;   // serial quotient complete

    typedef struct packed {
        logic signed [47:0] au;
        logic signed [47:0] bv;
        logic signed [47:0] du;
        logic signed [47:0] ev;
        logic signed [47:0] gu;
        logic signed [47:0] hv;
    } prod_t;

    typedef struct packed {
        logic signed [49:0] x;
        logic signed [49:0] y;
        logic signed [49:0] w;
    } sum_t;

    typedef struct packed {
        logic [65:0]        rem_x;
        logic [65:0]        rem_y;
        logic [47:0]        den;
        logic [16:0]        q_x;
        logic [16:0]        q_y;
        logic               neg_x;
        logic               neg_y;
        logic               ovf_x;
        logic               ovf_y;
        logic               degen;
        logic signed [17:0] w_out;
    } quo_stage_t;

    typedef enum logic [8:0] {
        D_IDLE = 9'b000000001,
        D_DIFF = 9'b000000010,
        D_MUL  = 9'b000000100,
        D_DET  = 9'b000001000,
        D_DIVG = 9'b000010000,
        D_DIVH = 9'b000100000,
        D_CMUL = 9'b001000000,
        D_CSUM = 9'b010000000,
        D_CRND = 9'b100000000
    } drv_state_t;

endpackage

[rtl/keystone_homography_warp.sv]
// Keystone correction: unit square to quadrilateral projective warp.
`timescale 1ns / 1ps
`include "keystone_homography_warp_macros.svh"

// Usage
//   Configuration: write corner registers 0..7 (x0,y0,x1,y1,x2,y2,x3,y3, Q2.14)
//   on cfg_valid/cfg_addr/cfg_wdata; cfg_ready is always high. Each write
//   restarts the coefficient derivation, most of which is spent in the
//   two one-bit-per-cycle divisions for g and h. s_tready stays low until
//   the new coefficients are in place.
//   Input: one word per cycle of (point_u, point_v) on the s_ channel while s_tready is high.
//   Output: one word per input on the m_ channel: out_x, out_y (Q2.14),
//   out_w (Q4.14) in m_tdata and the degenerate flag in m_tuser.
//   Pipeline: the word passes 22 register stages, the first loaded at
//   acceptance, with 17 restoring steps that form one quotient bit each.
//   Throughput: one word per cycle while m_tready is high and no derivation runs.
//   Reset: coefficients come up as the identity map, pipeline empty.
//   Stall: each stage holds while the next one is full and stalled; bubbles
//   close up, so the input keeps accepting until every stage is full.
module keystone_homography_warp (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // point_u [15:0], point_v [31:16]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // out_x [15:0], out_y [31:16], out_w [49:32], zero pad
    output logic        m_tuser    // degenerate [0]
);

    localparam int NST = khw_pkg::NSTAGE;
    localparam int NDV = khw_pkg::NDIV;

    // ---------------------------------------------------------------
    // Configuration and coefficient derivation
    // ---------------------------------------------------------------
    khw_pkg::corner_t    corner_reg [8];
    khw_pkg::coef_t      coef_reg   [8];
    logic                base_singular_reg;
    khw_pkg::drv_state_t state_reg;

    logic signed [16:0] dx1_reg, dx2_reg, dy1_reg, dy2_reg;
    logic signed [17:0] s_reg, t_reg;
    logic signed [35:0] pr_reg [6];
    logic signed [35:0] numg_reg, numh_reg, del_reg;
    khw_pkg::coef_t     g_reg, h_reg;
    logic signed [47:0] cm_reg [4];
    logic signed [49:0] cs_reg [4];

    logic [67:0] srem_reg, sdsh_reg;
    logic [31:0] sq_reg;
    logic [5:0]  scnt_reg;
    logic        sneg_reg, sovf_reg;

    logic signed [35:0] num_sel;
    logic [35:0]        num_mag, del_mag;
    logic [67:0]        srem_init;
    logic               sovf_init;

    // Round half away from zero from Q38 to Q24, clamp to 32 bits.
    function automatic khw_pkg::coef_t rnd_q24(input logic signed [49:0] v);
        logic [49:0] mag;
        logic [35:0] q;
        mag = v[49] ? 50'(-v) : 50'(v);
        q   = 36'((mag + 50'd8192) >> 14);
        if (v[49]) begin
            rnd_q24 = (q > 36'd2147483648) ? khw_pkg::COEF_MIN : 32'(-q);
        end else begin
            rnd_q24 = (q > 36'd2147483647) ? khw_pkg::COEF_MAX : q[31:0];
        end
    endfunction

    function automatic khw_pkg::coef_t sat32(input logic [31:0] q, input logic neg,
                                             input logic ovf);
        if (ovf) begin
            sat32 = neg ? khw_pkg::COEF_MIN : khw_pkg::COEF_MAX;
        end else if (neg) begin
            sat32 = (q > 32'h8000_0000) ? khw_pkg::COEF_MIN : 32'(32'd0 - q);
        end else begin
            sat32 = q[31] ? khw_pkg::COEF_MAX : q;
        end
    endfunction

    function automatic logic [15:0] sat16(input logic [16:0] q, input logic neg,
                                          input logic ovf);
        if (ovf) begin
            sat16 = neg ? 16'h8000 : 16'h7fff;
        end else if (neg) begin
            sat16 = (q > 17'd32768) ? 16'h8000 : 16'(16'd0 - q[15:0]);
        end else begin
            sat16 = (q > 17'd32767) ? 16'h7fff : q[15:0];
        end
    endfunction

    // Shared serial divider setup: |num| * 2^24 + |del| / 2 against |del|.
    always_comb begin
        num_sel   = (state_reg == khw_pkg::D_DIVG) ? numg_reg : numh_reg;
        num_mag   = num_sel[35] ? 36'(-num_sel) : 36'(num_sel);
        del_mag   = del_reg[35] ? 36'(-del_reg) : 36'(del_reg);
        srem_init = (68'(num_mag) << 24) + 68'(del_mag >> 1);
        sovf_init = srem_init >= (68'(del_mag) << 32);
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) begin
                corner_reg[i] <= (i == 2 || i == 4 || i == 5 || i == 7) ?
                                 khw_pkg::CORNER_ONE : '0;
                coef_reg[i]   <= (i == 0 || i == 4) ? khw_pkg::COEF_ONE : '0;
            end
            base_singular_reg <= 1'b0;
            state_reg         <= khw_pkg::D_IDLE;
            scnt_reg          <= '0;
        end else if (cfg_valid && cfg_ready) begin
            // a corner write restarts the derivation from the new corners
            corner_reg[cfg_addr] <= cfg_wdata;
            scnt_reg             <= '0;
            state_reg            <= khw_pkg::D_DIFF;
        end else begin
            case (state_reg)
                khw_pkg::D_IDLE: begin
                    scnt_reg <= '0;
                end
                khw_pkg::D_DIFF: begin
                    dx1_reg   <= 17'(corner_reg[2]) - 17'(corner_reg[4]);
                    dx2_reg   <= 17'(corner_reg[6]) - 17'(corner_reg[4]);
                    dy1_reg   <= 17'(corner_reg[3]) - 17'(corner_reg[5]);
                    dy2_reg   <= 17'(corner_reg[7]) - 17'(corner_reg[5]);
                    s_reg     <= 18'(corner_reg[0]) - 18'(corner_reg[2])
                               + 18'(corner_reg[4]) - 18'(corner_reg[6]);
                    t_reg     <= 18'(corner_reg[1]) - 18'(corner_reg[3])
                               + 18'(corner_reg[5]) - 18'(corner_reg[7]);
                    state_reg <= khw_pkg::D_MUL;
                end
                khw_pkg::D_MUL: begin
                    pr_reg[0] <= 36'(s_reg) * 36'(dy2_reg);
                    pr_reg[1] <= 36'(dx2_reg) * 36'(t_reg);
                    pr_reg[2] <= 36'(dx1_reg) * 36'(t_reg);
                    pr_reg[3] <= 36'(s_reg) * 36'(dy1_reg);
                    pr_reg[4] <= 36'(dx1_reg) * 36'(dy2_reg);
                    pr_reg[5] <= 36'(dx2_reg) * 36'(dy1_reg);
                    state_reg <= khw_pkg::D_DET;
                end
                khw_pkg::D_DET: begin
                    numg_reg  <= pr_reg[0] - pr_reg[1];
                    numh_reg  <= pr_reg[2] - pr_reg[3];
                    del_reg   <= pr_reg[4] - pr_reg[5];
                    scnt_reg  <= '0;
                    state_reg <= khw_pkg::D_DIVG;
                end
                khw_pkg::D_DIVG, khw_pkg::D_DIVH: begin
                    if (scnt_reg == '0) begin
                        if (del_reg == '0) begin
                            // singular base: zero map, every point degenerate
                            for (int i = 0; i < 8; i++) begin
                                coef_reg[i] <= '0;
                            end
                            base_singular_reg <= 1'b1;
                            state_reg         <= khw_pkg::D_IDLE;
                        end else begin
                            srem_reg <= srem_init;
                            sdsh_reg <= 68'(del_mag) << 31;
                            sq_reg   <= '0;
                            sneg_reg <= num_sel[35] ^ del_reg[35];
                            sovf_reg <= sovf_init;
                            scnt_reg <= scnt_reg + 6'd1;
                        end
                    end else if (scnt_reg <= khw_pkg::SDIV_LAST) begin
                        if (srem_reg >= sdsh_reg) begin
                            srem_reg <= srem_reg - sdsh_reg;
                            sq_reg   <= {sq_reg[30:0], 1'b1};
                        end else begin
                            sq_reg   <= {sq_reg[30:0], 1'b0};
                        end
                        sdsh_reg <= sdsh_reg >> 1;
                        scnt_reg <= scnt_reg + 6'd1;
                    end else begin
                        scnt_reg <= '0;
                        if (state_reg == khw_pkg::D_DIVG) begin
                            g_reg     <= sat32(sq_reg, sneg_reg, sovf_reg);
                            state_reg <= khw_pkg::D_DIVH;
                        end else begin
                            h_reg     <= sat32(sq_reg, sneg_reg, sovf_reg);
                            state_reg <= khw_pkg::D_CMUL;
                        end
                    end
                end
                khw_pkg::D_CMUL: begin
                    cm_reg[0] <= 48'(g_reg) * 48'(corner_reg[2]);
                    cm_reg[1] <= 48'(h_reg) * 48'(corner_reg[6]);
                    cm_reg[2] <= 48'(g_reg) * 48'(corner_reg[3]);
                    cm_reg[3] <= 48'(h_reg) * 48'(corner_reg[7]);
                    state_reg <= khw_pkg::D_CSUM;
                end
                khw_pkg::D_CSUM: begin
                    cs_reg[0] <= ((50'(corner_reg[2]) - 50'(corner_reg[0])) <<< 24)
                               + 50'(cm_reg[0]);
                    cs_reg[1] <= ((50'(corner_reg[6]) - 50'(corner_reg[0])) <<< 24)
                               + 50'(cm_reg[1]);
                    cs_reg[2] <= ((50'(corner_reg[3]) - 50'(corner_reg[1])) <<< 24)
                               + 50'(cm_reg[2]);
                    cs_reg[3] <= ((50'(corner_reg[7]) - 50'(corner_reg[1])) <<< 24)
                               + 50'(cm_reg[3]);
                    state_reg <= khw_pkg::D_CRND;
                end
                khw_pkg::D_CRND: begin
                    coef_reg[0]       <= rnd_q24(cs_reg[0]);
                    coef_reg[1]       <= rnd_q24(cs_reg[1]);
                    coef_reg[2]       <= 32'(corner_reg[0]) <<< 10;
                    coef_reg[3]       <= rnd_q24(cs_reg[2]);
                    coef_reg[4]       <= rnd_q24(cs_reg[3]);
                    coef_reg[5]       <= 32'(corner_reg[1]) <<< 10;
                    coef_reg[6]       <= g_reg;
                    coef_reg[7]       <= h_reg;
                    base_singular_reg <= 1'b0;
                    state_reg         <= khw_pkg::D_IDLE;
                end
                default: begin
                    state_reg <= khw_pkg::D_IDLE;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Point pipeline
    // ---------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] rdy;

    khw_pkg::prod_t      prod_reg, prod_next;
    khw_pkg::sum_t       sum_reg,  sum_next;
    khw_pkg::quo_stage_t dv_reg  [NDV];
    khw_pkg::quo_stage_t dv_next [NDV];
    logic [55:0]         m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    khw_pkg::corner_t   pu, pv;
    logic signed [49:0] xm, ym, wm;
    logic [24:0]        wq;
    logic [65:0]        dsh;

    // A stage takes a new word when it is empty or its word moves on.
    always_comb begin
        rdy[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int i = NST - 2; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign s_tready = rdy[0] && (state_reg == khw_pkg::D_IDLE) && !cfg_valid;

    always_comb begin
        // products
        pu = s_tdata[15:0];
        pv = s_tdata[31:16];
        prod_next.au = 48'(coef_reg[0]) * 48'(pu);
        prod_next.bv = 48'(coef_reg[1]) * 48'(pv);
        prod_next.du = 48'(coef_reg[3]) * 48'(pu);
        prod_next.ev = 48'(coef_reg[4]) * 48'(pv);
        prod_next.gu = 48'(coef_reg[6]) * 48'(pu);
        prod_next.hv = 48'(coef_reg[7]) * 48'(pv);

        // homogeneous sums in Q38
        sum_next.x = 50'(prod_reg.au) + 50'(prod_reg.bv) + (50'(coef_reg[2]) <<< 14);
        sum_next.y = 50'(prod_reg.du) + 50'(prod_reg.ev) + (50'(coef_reg[5]) <<< 14);
        sum_next.w = 50'(prod_reg.gu) + 50'(prod_reg.hv) + khw_pkg::W_BIAS;

        // sign-magnitude split, rounding bias, w output
        xm = sum_reg.x[49] ? -sum_reg.x : sum_reg.x;
        ym = sum_reg.y[49] ? -sum_reg.y : sum_reg.y;
        wm = sum_reg.w[49] ? -sum_reg.w : sum_reg.w;
        wq = 25'((50'(wm) + 50'd8388608) >> 24);
        dv_next[0].den   = wm[47:0];
        dv_next[0].rem_x = (66'(xm[47:0]) << 14) + 66'(wm[47:1]);
        dv_next[0].rem_y = (66'(ym[47:0]) << 14) + 66'(wm[47:1]);
        dv_next[0].q_x   = '0;
        dv_next[0].q_y   = '0;
        dv_next[0].neg_x = sum_reg.x[49] ^ sum_reg.w[49];
        dv_next[0].neg_y = sum_reg.y[49] ^ sum_reg.w[49];
        dv_next[0].ovf_x = 1'b0;
        dv_next[0].ovf_y = 1'b0;
        dv_next[0].degen = base_singular_reg || (sum_reg.w == '0);
        if (sum_reg.w[49]) begin
            dv_next[0].w_out = (wq > 25'd131072) ? -18'sd131072 : 18'(25'd0 - wq);
        end else begin
            dv_next[0].w_out = (wq > 25'd131071) ? 18'sd131071 : wq[17:0];
        end

        // quotient beyond 17 bits saturates
        dv_next[1]       = dv_reg[0];
        dv_next[1].ovf_x = dv_reg[0].rem_x >= (66'(dv_reg[0].den) << khw_pkg::DIV_STEPS);
        dv_next[1].ovf_y = dv_reg[0].rem_y >= (66'(dv_reg[0].den) << khw_pkg::DIV_STEPS);

        // restoring steps, one quotient bit per stage, MSB first
        dsh = '0;
        for (int k = 2; k < NDV; k++) begin
            dv_next[k] = dv_reg[k-1];
            dsh = 66'(dv_reg[k-1].den) << (NDV - 1 - k);
            if (dv_reg[k-1].rem_x >= dsh) begin
                dv_next[k].rem_x            = dv_reg[k-1].rem_x - dsh;
                dv_next[k].q_x[NDV - 1 - k] = 1'b1;
            end
            if (dv_reg[k-1].rem_y >= dsh) begin
                dv_next[k].rem_y            = dv_reg[k-1].rem_y - dsh;
                dv_next[k].q_y[NDV - 1 - k] = 1'b1;
            end
        end

        // output word, zero on a degenerate point
        if (dv_reg[NDV-1].degen) begin
            m_tdata_next = '0;
        end else begin
            m_tdata_next = {6'd0, dv_reg[NDV-1].w_out,
                            sat16(dv_reg[NDV-1].q_y, dv_reg[NDV-1].neg_y, dv_reg[NDV-1].ovf_y),
                            sat16(dv_reg[NDV-1].q_x, dv_reg[NDV-1].neg_x, dv_reg[NDV-1].ovf_x)};
        end
        m_tuser_next = dv_reg[NDV-1].degen;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_tvalid && s_tready;
            end
            for (int i = 1; i < NST; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            prod_reg <= prod_next;
        end
        if (rdy[1]) begin
            sum_reg <= sum_next;
        end
        for (int k = 0; k < NDV; k++) begin
            if (rdy[k+2]) begin
                dv_reg[k] <= dv_next[k];
            end
        end
        if (rdy[NST-1]) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `KHW_IMPLY(a_degen_zero, m_tvalid && m_tuser, m_tdata == '0, "degenerate word carries data")
    `KHW_IMPLY(a_singular_zero, base_singular_reg && (state_reg == khw_pkg::D_IDLE), (coef_reg[6] == '0) && (coef_reg[7] == '0), "singular base left nonzero coefficients")
    `KHW_NEXT(a_cfg_restart, cfg_valid && cfg_ready, state_reg == khw_pkg::D_DIFF, "corner write did not restart derivation")
    `KHW_NEXT(a_stage_hold, vld_reg[2] && !rdy[2], vld_reg[2], "stalled stage dropped its word")

endmodule

[sim/khw_checker.sv]
// Checker for the keystone warp: predicts each result word and compares it.
`timescale 1ns / 1ps

module khw_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [17:0] pw;
        logic               degen;
    } warp_out_t;

    longint         corner[8];
    khw_pkg::coef_t coef[8];
    bit             singular;
    warp_out_t      warp_q[$];

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Round half away from zero, then clamp.
    function automatic longint div_rnd(longint num, longint den, longint lo, longint hi);
        longint n, d, q;
        bit neg;
        n = mag(num);
        d = mag(den);
        q = (n + d / 2) / d;
        neg = (num < 0) != (den < 0);
        if (neg) return (q > -lo) ? lo : -q;
        return (q > hi) ? hi : q;
    endfunction

    function automatic khw_pkg::coef_t q38_to_q24(longint v);
        return khw_pkg::coef_t'(div_rnd(v, 64'sd16384, -64'sd2147483648, 64'sd2147483647));
    endfunction

    task automatic rederive();
        longint x0, y0, x1, y1, x2, y2, x3, y3, dx1, dx2, dy1, dy2, s, t, del, g, h;
        x0 = corner[0]; y0 = corner[1]; x1 = corner[2]; y1 = corner[3];
        x2 = corner[4]; y2 = corner[5]; x3 = corner[6]; y3 = corner[7];
        dx1 = x1 - x2; dx2 = x3 - x2; dy1 = y1 - y2; dy2 = y3 - y2;
        s = x0 - x1 + x2 - x3; t = y0 - y1 + y2 - y3;
        del = dx1 * dy2 - dx2 * dy1;
        if (del == 0) begin
            singular = 1;
            for (int i = 0; i < 8; i++) coef[i] = '0;
        end else begin
            singular = 0;
            g = div_rnd((s * dy2 - dx2 * t) * (64'sd1 << 24), del,
                        -64'sd2147483648, 64'sd2147483647);
            h = div_rnd((dx1 * t - s * dy1) * (64'sd1 << 24), del,
                        -64'sd2147483648, 64'sd2147483647);
            coef[0] = q38_to_q24((x1 - x0) * (64'sd1 << 24) + g * x1);
            coef[1] = q38_to_q24((x3 - x0) * (64'sd1 << 24) + h * x3);
            coef[2] = q38_to_q24(x0 * (64'sd1 << 24));
            coef[3] = q38_to_q24((y1 - y0) * (64'sd1 << 24) + g * y1);
            coef[4] = q38_to_q24((y3 - y0) * (64'sd1 << 24) + h * y3);
            coef[5] = q38_to_q24(y0 * (64'sd1 << 24));
            coef[6] = khw_pkg::coef_t'(g);
            coef[7] = khw_pkg::coef_t'(h);
        end
    endtask

    function automatic warp_out_t project_point(logic [15:0] u_raw, logic [15:0] v_raw);
        warp_out_t r;
        longint u, v, x, y, w;
        u = longint'($signed(u_raw));
        v = longint'($signed(v_raw));
        x = longint'(coef[0]) * u + longint'(coef[1]) * v + longint'(coef[2]) * 16384;
        y = longint'(coef[3]) * u + longint'(coef[4]) * v + longint'(coef[5]) * 16384;
        w = longint'(coef[6]) * u + longint'(coef[7]) * v + (64'sd1 << 38);
        r = '0;
        if (singular || w == 0) begin
            r.degen = 1;
        end else begin
            r.px = 16'(div_rnd(x * 16384, w, -32768, 32767));
            r.py = 16'(div_rnd(y * 16384, w, -32768, 32767));
            r.pw = 18'(div_rnd(w, 64'sd1 << 24, -131072, 131071));
        end
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        warp_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) corner[i] = 0;
            corner[2] = 16384; corner[4] = 16384; corner[5] = 16384; corner[7] = 16384;
            rederive();
            warp_q.delete();
            fail_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (warp_q.size() == 0) begin
                    report("unexpected word", longint'(m_tdata[49:0]), 0);
                end else begin
                    want = warp_q.pop_front();
                    if ($signed(m_tdata[15:0]) != want.px)
                        report("out_x", $signed(m_tdata[15:0]), want.px);
                    if ($signed(m_tdata[31:16]) != want.py)
                        report("out_y", $signed(m_tdata[31:16]), want.py);
                    if ($signed(m_tdata[49:32]) != want.pw)
                        report("out_w", $signed(m_tdata[49:32]), want.pw);
                    if (m_tuser != want.degen)
                        report("degenerate", m_tuser, want.degen);
                end
            end
            if (s_tvalid && s_tready)
                warp_q.push_back(project_point(s_tdata[15:0], s_tdata[31:16]));
            if (cfg_valid && cfg_ready) begin
                corner[cfg_addr] = longint'($signed(cfg_wdata));
                rederive();
            end
        end
        pending = warp_q.size();
    end
endmodule

[sim/tb_top.sv]
// Testbench top for the keystone warp: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;

    localparam int DRAIN_CYCLES = 120;      // latency plus derivation slack
    localparam int STUCK_LIMIT  = 20000;    // idle cycles before giving up

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic [2:0]  cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // point_u [15:0], point_v [31:16]
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [55:0] m_tdata;        // out_x [15:0], out_y [31:16], out_w [49:32]
    logic        m_tuser;        // degenerate [0]

    int fail_count, pending;
    int send_idle_pct = 0, recv_idle_pct = 0;
    int stuck = 0;

    always #5 aclk = ~aclk;

    keystone_homography_warp u_dut (.*);

    khw_checker u_chk (.*);

    // Advance the sink's ready at each falling edge.
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // End the run if nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stuck <= 0;
        else
            stuck <= stuck + 1;
        if (stuck >= STUCK_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Send one point word from a falling edge; hold it until accepted and
    // return at the next falling edge, so words can follow back to back.
    task automatic send_point(logic [15:0] u, logic [15:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {v, u};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every expected word has come out.
    task automatic drain();
        s_tvalid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_corner(logic [2:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_valid <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 0;
    endtask

    task automatic load_quad(logic [15:0] c[8]);
        for (int i = 0; i < 8; i++) write_corner(3'(i), c[i]);
    endtask

    // Mostly moderate points, with occasional full-range ones.
    task automatic random_points(int n);
        logic [15:0] u, v;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) begin
                u = 16'($urandom); v = 16'($urandom);
            end else begin
                u = 16'($signed($urandom_range(24576)) - 4096);
                v = 16'($signed($urandom_range(24576)) - 4096);
            end
            send_point(u, v);
        end
    endtask

    initial begin
        logic [15:0] quad[8];
        logic [15:0] edge_vals[6];
        edge_vals = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h4000, 16'h2000};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: identity map and field extremes.
        send_idle_pct = 0; recv_idle_pct = 0;
        for (int i = 0; i < 6; i++)
            for (int j = 0; j < 3; j++)
                send_point(edge_vals[i], edge_vals[j * 2 + 1]);
        drain();

        // Singular base: every corner at the origin.
        quad = '{default: 16'h0000};
        load_quad(quad);
        send_point(16'h1234, 16'h8000);
        send_point(16'h7fff, 16'h7fff);
        drain();

        // Projective quad with w reaching zero: g = 0, h = -3 puts w = 0 at v = 1/3.
        quad = '{16'h0000, 16'h0000, 16'h8000, 16'h0000,
                 16'h4000, 16'h4000, 16'h0000, 16'h4000};
        load_quad(quad);
        send_point(16'h4000, 16'h0000);
        send_point(16'h4000, 16'h7fff);
        send_point(16'h2000, 16'h2000);
        drain();

        // Extreme corners.
        quad = '{16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                 16'h7fff, 16'h7fff, 16'h8000, 16'h8000};
        load_quad(quad);
        random_points(4);
        drain();

        // Random quads under three idling profiles.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 3)
                0: begin send_idle_pct = 14; recv_idle_pct = 57; end
                1: begin send_idle_pct = 57; recv_idle_pct = 14; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int i = 0; i < 8; i++) begin
                if (phase == 5)
                    quad[i] = 16'($urandom);
                else
                    quad[i] = 16'($signed($urandom_range(12000)) - 6000)
                              + ((i == 2 || i == 4 || i == 5 || i == 7) ? 16'h4000 : 16'h0000);
            end
            load_quad(quad);
            random_points(33);
            drain();
            random_points(33);
            drain();
        end

        drain();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
